// ===== design/framed_line_time_command_parser_top_assert.svh =====
// Assertion macros shared by the parser modules.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef FRAMED_LINE_TIME_COMMAND_PARSER_TOP_ASSERT_SVH
`define FRAMED_LINE_TIME_COMMAND_PARSER_TOP_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define FLTCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the next cycle.
`define FLTCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Condition holds at every edge.
`define FLTCP_ASSERT_INV(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) 1'b1 |-> (cond)) \
    else $error(msg);

`endif

// ===== design/fltcp_pkg.sv =====
`timescale 1ns / 1ps

package fltcp_pkg;

  localparam int unsigned LINE_MAX    = 512;
  localparam int unsigned KEPT_W      = $clog2(LINE_MAX);
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 9;
  localparam int unsigned ACC_W       = 32;
  localparam int unsigned TIME_W      = 2 * ACC_W;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] CH_AT     = 8'h40;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_T      = 8'h54;
  localparam logic [BYTE_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_VTAB   = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF     = 8'h0C;

  typedef enum logic [1:0] {
    FR_WAIT = 2'd0,
    FR_AT   = 2'd1,
    FR_RECV = 2'd2
  } frame_e;

  typedef enum logic [2:0] {
    PH_T     = 3'd0,
    PH_EQ    = 3'd1,
    PH_WS_HI = 3'd2,
    PH_HI    = 3'd3,
    PH_WS_LO = 3'd4,
    PH_LO    = 3'd5,
    PH_DONE  = 3'd6
  } parse_e;

  typedef struct packed {
    logic              eol;
    logic [KEPT_W-1:0] len;
    logic [BYTE_W-1:0] data;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_xfer_t;

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VTAB) || (c == CH_FF);
  endfunction

  function automatic logic is_eol(input logic [BYTE_W-1:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

// ===== design/fltcp_ifs.sv =====
`timescale 1ns / 1ps

interface fltcp_byte_if;
  logic                           valid;
  logic                           ready;
  logic [fltcp_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fltcp_result_if;
  logic                           valid;
  logic                           ready;
  logic [fltcp_pkg::LEN_W-1:0]    payload_length;
  logic                           is_time_command;
  logic [fltcp_pkg::TIME_W-1:0]   time_value;

  modport source (output valid, output payload_length, output is_time_command,
                  output time_value, input ready);
  modport sink   (input valid, input payload_length, input is_time_command,
                  input time_value, output ready);
endinterface

// ===== design/fltcp_front.sv =====
`timescale 1ns / 1ps
`include "framed_line_time_command_parser_top_assert.svh"

module fltcp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fltcp_byte_if.sink           rx_i,
  input  logic                 q_full_i,
  output fltcp_pkg::q_xfer_t   push_o
);

  fltcp_pkg::frame_e                frame_q, frame_d;
  logic [fltcp_pkg::KEPT_W-1:0]     kept_q, kept_d;
  logic                             accept;
  logic                             eol;
  logic                             room;

  assign rx_i.ready = !q_full_i;
  assign accept     = rx_i.valid && rx_i.ready;
  assign eol        = fltcp_pkg::is_eol(rx_i.rx_byte);
  assign room       = kept_q < fltcp_pkg::KEPT_W'(fltcp_pkg::LINE_MAX - 1);

  // Next state
  always_comb begin
    frame_d = frame_q;
    if (accept) begin
      case (frame_q)
        fltcp_pkg::FR_AT: begin
          frame_d = (rx_i.rx_byte == fltcp_pkg::CH_DOLLAR) ? fltcp_pkg::FR_RECV
                                                           : fltcp_pkg::FR_WAIT;
        end
        fltcp_pkg::FR_RECV: begin
          if (eol) begin
            frame_d = fltcp_pkg::FR_WAIT;
          end
        end
        default: begin
          frame_d = (rx_i.rx_byte == fltcp_pkg::CH_AT) ? fltcp_pkg::FR_AT
                                                       : fltcp_pkg::FR_WAIT;
        end
      endcase
    end
  end

  // Outputs: forward kept payload bytes and the line end
  always_comb begin
    kept_d            = kept_q;
    push_o.valid      = 1'b0;
    push_o.entry.eol  = eol;
    push_o.entry.len  = kept_q;
    push_o.entry.data = rx_i.rx_byte;
    if (accept) begin
      case (frame_q)
        fltcp_pkg::FR_RECV: begin
          if (eol) begin
            push_o.valid = 1'b1;
            kept_d       = '0;
          end else if (room) begin
            push_o.valid = 1'b1;
            kept_d       = kept_q + 1'b1;
          end
        end
        default: begin
          kept_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= fltcp_pkg::FR_WAIT;
      kept_q  <= '0;
    end else begin
      frame_q <= frame_d;
      kept_q  <= kept_d;
    end
  end

  `FLTCP_ASSERT_IMP(a_kept_clear_outside_line, frame_q != fltcp_pkg::FR_RECV, kept_q == '0,
                    "kept count not clear outside a line")

endmodule

// ===== design/fltcp_queue.sv =====
`timescale 1ns / 1ps
`include "framed_line_time_command_parser_top_assert.svh"

module fltcp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fltcp_pkg::q_xfer_t   push_i,
  output logic                 full_o,
  output fltcp_pkg::q_xfer_t   head_o,
  input  logic                 pop_i
);

  fltcp_pkg::q_entry_t              mem_q [fltcp_pkg::QUEUE_DEPTH];
  logic [fltcp_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [fltcp_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [fltcp_pkg::QCNT_W-1:0]     count_q, count_d;
  logic                             do_push;
  logic                             do_pop;

  assign full_o       = count_q == fltcp_pkg::QCNT_W'(fltcp_pkg::QUEUE_DEPTH);
  assign head_o.valid = count_q != '0;
  assign head_o.entry = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == fltcp_pkg::QPTR_W'(fltcp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == fltcp_pkg::QPTR_W'(fltcp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  `FLTCP_ASSERT_INV(a_count_in_range,
                    count_q <= fltcp_pkg::QCNT_W'(fltcp_pkg::QUEUE_DEPTH),
                    "queue count beyond depth")
  `FLTCP_ASSERT_IMP(a_no_pop_when_empty, pop_i, count_q != '0, "pop from empty queue")

endmodule

// ===== design/fltcp_back.sv =====
`timescale 1ns / 1ps
`include "framed_line_time_command_parser_top_assert.svh"

module fltcp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fltcp_pkg::q_xfer_t   head_i,
  output logic                 pop_o,
  fltcp_result_if.source       res_o
);

  fltcp_pkg::parse_e                phase_q, phase_d;
  logic                             failed_q, failed_d;
  logic [fltcp_pkg::ACC_W-1:0]      hi_q, hi_d;
  logic [fltcp_pkg::ACC_W-1:0]      lo_q, lo_d;
  logic                             vld_q, vld_d;
  logic [fltcp_pkg::LEN_W-1:0]      len_q, len_d;
  logic                             cmd_q, cmd_d;
  logic [fltcp_pkg::TIME_W-1:0]     time_q, time_d;
  logic [fltcp_pkg::BYTE_W-1:0]     c;
  logic                             digit;
  logic                             blank;
  logic [fltcp_pkg::ACC_W-1:0]      dval;
  logic                             take_byte;
  logic                             take_eol;
  logic                             ok;

  assign c         = head_i.entry.data;
  assign digit     = fltcp_pkg::is_digit(c);
  assign blank     = fltcp_pkg::is_blank(c);
  assign dval      = fltcp_pkg::ACC_W'(c - fltcp_pkg::CH_ZERO);
  // A line end waits for the result register to be free; payload bytes never wait
  assign pop_o     = head_i.valid && (!head_i.entry.eol || !vld_q || res_o.ready);
  assign take_byte = pop_o && !head_i.entry.eol;
  assign take_eol  = pop_o && head_i.entry.eol;
  assign ok        = !failed_q && ((phase_q == fltcp_pkg::PH_LO) ||
                                   (phase_q == fltcp_pkg::PH_DONE));

  // Next parse state
  always_comb begin
    phase_d  = phase_q;
    failed_d = failed_q;
    if (take_eol) begin
      phase_d  = fltcp_pkg::PH_T;
      failed_d = 1'b0;
    end else if (take_byte && !failed_q) begin
      case (phase_q)
        fltcp_pkg::PH_T: begin
          if (c == fltcp_pkg::CH_T) phase_d = fltcp_pkg::PH_EQ;
          else failed_d = 1'b1;
        end
        fltcp_pkg::PH_EQ: begin
          if (c == fltcp_pkg::CH_EQ) phase_d = fltcp_pkg::PH_WS_HI;
          else failed_d = 1'b1;
        end
        fltcp_pkg::PH_WS_HI: begin
          if (digit) phase_d = fltcp_pkg::PH_HI;
          else if (!blank) failed_d = 1'b1;
        end
        fltcp_pkg::PH_HI: begin
          if (digit) phase_d = fltcp_pkg::PH_HI;
          else if (c == fltcp_pkg::CH_COMMA) phase_d = fltcp_pkg::PH_WS_LO;
          else failed_d = 1'b1;
        end
        fltcp_pkg::PH_WS_LO: begin
          if (digit) phase_d = fltcp_pkg::PH_LO;
          else if (!blank) failed_d = 1'b1;
        end
        fltcp_pkg::PH_LO: begin
          if (!digit) phase_d = fltcp_pkg::PH_DONE;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // Accumulators and result register
  always_comb begin
    hi_d   = hi_q;
    lo_d   = lo_q;
    vld_d  = vld_q && !res_o.ready;
    len_d  = len_q;
    cmd_d  = cmd_q;
    time_d = time_q;
    if (take_eol) begin
      hi_d   = '0;
      lo_d   = '0;
      vld_d  = 1'b1;
      len_d  = fltcp_pkg::LEN_W'(head_i.entry.len);
      cmd_d  = ok;
      time_d = ok ? {hi_q, lo_q} : '0;
    end else if (take_byte && !failed_q && digit) begin
      case (phase_q)
        fltcp_pkg::PH_WS_HI: hi_d = dval;
        fltcp_pkg::PH_HI:    hi_d = (hi_q << 3) + (hi_q << 1) + dval;
        fltcp_pkg::PH_WS_LO: lo_d = dval;
        fltcp_pkg::PH_LO:    lo_d = (lo_q << 3) + (lo_q << 1) + dval;
        default: begin
          hi_d = hi_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= fltcp_pkg::PH_T;
      failed_q <= 1'b0;
      hi_q     <= '0;
      lo_q     <= '0;
      vld_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      failed_q <= failed_d;
      hi_q     <= hi_d;
      lo_q     <= lo_d;
      vld_q    <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    cmd_q  <= cmd_d;
    time_q <= time_d;
  end

  assign res_o.valid           = vld_q;
  assign res_o.payload_length  = len_q;
  assign res_o.is_time_command = cmd_q;
  assign res_o.time_value      = time_q;

  `FLTCP_ASSERT_NXT(a_parse_restart_after_eol, take_eol,
                    (phase_q == fltcp_pkg::PH_T) && !failed_q && vld_q,
                    "parser not restarted after line end")
  `FLTCP_ASSERT_IMP(a_time_zero_unless_cmd, vld_q && !cmd_q, time_q == '0,
                    "time value set on a line that is not a command")

endmodule

// ===== design/framed_line_time_command_parser_top.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload                                                  Transfer
// rx_i      in   rx_byte[7:0]                                             valid && ready
// res_o     out  payload_length[8:0], is_time_command, time_value[63:0]   valid && ready
//
// One byte per cycle unless the queue is full; each result is registered after the queue.
// Each digit of a number costs one pass through the parser's multiply-by-ten accumulate.
// Reset is asynchronous, active low, and leaves the block waiting for the preamble.
// A two-entry queue parts byte intake from parsing; rx_i stalls only when it is full,
// which happens when a line end waits on a result still held on res_o.

module framed_line_time_command_parser_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  fltcp_byte_if.sink        rx_i,
  fltcp_result_if.source    res_o
);

  fltcp_pkg::q_xfer_t  push;
  fltcp_pkg::q_xfer_t  head;
  logic                q_full;
  logic                pop;

  fltcp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx_i     (rx_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  fltcp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  fltcp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .res_o  (res_o)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import fltcp_pkg::*;

  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_FILL  = 8'h78;
  localparam logic [BYTE_W-1:0] CH_LOW_T = 8'h74;
  localparam logic [BYTE_W-1:0] CH_HIGH  = 8'hFF;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

  localparam int unsigned KEEP_LIMIT   = LINE_MAX - 1;
  localparam int unsigned RANDOM_BYTES = 550;
  localparam int unsigned CALM_BYTES   = 150;
  localparam int unsigned LONG_STALL   = 300;
  localparam int unsigned DRAIN_LIMIT  = 20000;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic              is_cmd;
    logic [TIME_W-1:0] stamp;
  } line_result_t;

  logic clk_i;
  logic rst_ni;

  fltcp_byte_if   rx_if ();
  fltcp_result_if res_if ();

  framed_line_time_command_parser_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  line_result_t       pending_lines[$];
  logic [BYTE_W-1:0]  line_buf[$];
  line_result_t       want;
  int unsigned        errors      = 0;
  int unsigned        bytes_sent  = 0;
  int unsigned        stall_req   = 0;
  bit                 calm        = 1'b0;
  bit                 sender_gaps = 1'b1;

  // line tracker state
  frame_e             frame_st   = FR_WAIT;
  int unsigned        kept_len   = 0;
  parse_e             parse_st   = PH_T;
  logic [ACC_W-1:0]   hi_acc     = '0;
  logic [ACC_W-1:0]   lo_acc     = '0;
  logic               cmd_broken = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic void line_clear();
    kept_len   = 0;
    parse_st   = PH_T;
    hi_acc     = '0;
    lo_acc     = '0;
    cmd_broken = 1'b0;
  endfunction

  // Advance the T=<hi>,<lo> recogniser by one kept payload byte.
  function automatic void parse_char(input logic [BYTE_W-1:0] c);
    logic             digit;
    logic             blank;
    logic [ACC_W-1:0] val;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VTAB) || (c == CH_FF);
    val   = ACC_W'(c - CH_ZERO);
    if (cmd_broken) return;
    case (parse_st)
      PH_T: begin
        if (c == CH_T) parse_st = PH_EQ;
        else cmd_broken = 1'b1;
      end
      PH_EQ: begin
        if (c == CH_EQ) parse_st = PH_WS_HI;
        else cmd_broken = 1'b1;
      end
      PH_WS_HI: begin
        if (digit) begin
          hi_acc   = val;
          parse_st = PH_HI;
        end else if (!blank) begin
          cmd_broken = 1'b1;
        end
      end
      PH_HI: begin
        if (digit) hi_acc = hi_acc * 32'd10 + val;
        else if (c == CH_COMMA) parse_st = PH_WS_LO;
        else cmd_broken = 1'b1;
      end
      PH_WS_LO: begin
        if (digit) begin
          lo_acc   = val;
          parse_st = PH_LO;
        end else if (!blank) begin
          cmd_broken = 1'b1;
        end
      end
      PH_LO: begin
        if (digit) lo_acc = lo_acc * 32'd10 + val;
        else parse_st = PH_DONE;
      end
      default: ;
    endcase
  endfunction

  function automatic void track_line_byte(input logic [BYTE_W-1:0] c);
    line_result_t r;
    if (frame_st == FR_AT) begin
      frame_st = (c == CH_DOLLAR) ? FR_RECV : FR_WAIT;
      line_clear();
    end else if (frame_st != FR_RECV) begin
      line_clear();
      frame_st = (c == CH_AT) ? FR_AT : FR_WAIT;
    end else if (c == CH_CR || c == CH_LF) begin
      r.is_cmd = !cmd_broken && (parse_st == PH_LO || parse_st == PH_DONE);
      r.len    = LEN_W'(kept_len);
      r.stamp  = r.is_cmd ? {hi_acc, lo_acc} : '0;
      pending_lines.push_back(r);
      frame_st = FR_WAIT;
      line_clear();
    end else if (kept_len < KEEP_LIMIT) begin
      kept_len++;
      parse_char(c);
    end
  endfunction

  function automatic void mismatch(input string what, input logic [TIME_W-1:0] exp_v,
                                   input logic [TIME_W-1:0] act_v);
    errors++;
    $display("%0t: %s expected %0h actual %0h", $time, what, exp_v, act_v);
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_lines.size() == 0) begin
        mismatch("unexpected result, payload_length", '0, TIME_W'(res_if.payload_length));
      end else begin
        want = pending_lines.pop_front();
        if (res_if.payload_length !== want.len)
          mismatch("payload_length", TIME_W'(want.len), TIME_W'(res_if.payload_length));
        if (res_if.is_time_command !== want.is_cmd)
          mismatch("is_time_command", TIME_W'(want.is_cmd), TIME_W'(res_if.is_time_command));
        if (res_if.time_value !== want.stamp)
          mismatch("time_value", want.stamp, res_if.time_value);
      end
    end
  end

  // Result-side pacing; a requested long stall takes priority.
  initial begin
    int unsigned span;
    forever begin
      if (stall_req != 0) begin
        span      = stall_req;
        stall_req = 0;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        span = $urandom_range(1, 11);
        res_if.ready <= 1'b0;
      end else begin
        span = $urandom_range(1, 24);
        res_if.ready <= 1'b1;
      end
      repeat (span) @(posedge clk_i);
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned pause;
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    track_line_byte(b);
    bytes_sent++;
    if (sender_gaps && !calm && $urandom_range(0, 9) == 0) begin
      pause = $urandom_range(1, 11);
      rx_if.valid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_fill(input int unsigned n);
    repeat (n) send_byte(CH_FILL);
  endtask

  function automatic logic [BYTE_W-1:0] payload_char();
    logic [BYTE_W-1:0] c;
    do c = BYTE_W'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
    return c;
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void add_blanks();
    int unsigned n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       line_buf.push_back(CH_SPACE);
        1:       line_buf.push_back(CH_TAB);
        2:       line_buf.push_back(CH_VTAB);
        default: line_buf.push_back(CH_FF);
      endcase
    end
  endfunction

  function automatic void add_number();
    logic [63:0] v;
    case ($urandom_range(0, 3))
      0:       v = $urandom_range(0, 9);
      1:       v = $urandom_range(0, 99999);
      2:       v = $urandom;
      default: v = {$urandom, $urandom};
    endcase
    if ($urandom_range(0, 7) == 0) line_buf.push_back(CH_ZERO);
    add_text($sformatf("%0d", v));
  endfunction

  task automatic random_line();
    int unsigned kind;
    int unsigned n;
    int unsigned body;
    int unsigned pos;
    line_buf.delete();
    // noise outside a frame, closed by a line end so the preamble below stands
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) line_buf.push_back(BYTE_W'($urandom_range(0, 255)));
      line_buf.push_back(CH_LF);
    end
    line_buf.push_back(CH_AT);
    line_buf.push_back(CH_DOLLAR);
    body = line_buf.size();
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      line_buf.push_back(CH_T);
      line_buf.push_back(CH_EQ);
      add_blanks();
      add_number();
      line_buf.push_back(CH_COMMA);
      add_blanks();
      add_number();
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 5);
        repeat (n) line_buf.push_back(payload_char());
      end
      if (kind >= 65) begin
        pos = $urandom_range(body, line_buf.size() - 1);
        case ($urandom_range(0, 2))
          0:       line_buf[pos] = CH_PLUS;
          1:       line_buf[pos] = CH_MINUS;
          default: line_buf[pos] = BYTE_W'($urandom_range(0, 255));
        endcase
      end
    end else begin
      n = $urandom_range(0, 12);
      repeat (n) line_buf.push_back(payload_char());
    end
    line_buf.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
    foreach (line_buf[i]) send_byte(line_buf[i]);
  endtask

  task automatic test_time_commands();
    send_text("@$T=1,2");
    send_byte(CH_CR);
    send_text("@$T=0,0");
    send_byte(CH_LF);
    send_text("@$T=4294967295,4294967295");
    send_byte(CH_LF);
    // every blank kind before the numbers, then trailing text
    send_text("@$T=");
    send_byte(CH_TAB);
    send_byte(CH_SPACE);
    send_text("12,");
    send_byte(CH_VTAB);
    send_byte(CH_FF);
    send_text("34 tail");
    send_byte(CH_HIGH);
    send_byte(CH_CR);
    // both numbers wrap
    send_text("@$T=4294967296,18446744073709551621");
    send_byte(CH_LF);
  endtask

  task automatic test_framing();
    send_text("@$");
    send_byte(CH_CR);
    // line ends and stray bytes while waiting give nothing
    send_byte(CH_NUL);
    send_byte(CH_HIGH);
    send_byte(CH_CR);
    send_byte(CH_DOLLAR);
    send_byte(CH_LF);
    // a second '@' right after '@' breaks the preamble and is not a new start
    send_text("@@$T=5,6");
    send_byte(CH_LF);
    send_text("@x@$T=3,4");
    send_byte(CH_LF);
    send_text("@$");
    send_byte(CH_NUL);
    send_text("T=1,2");
    send_byte(CH_CR);
    send_text("@$T=1,2");
    send_byte(CH_NUL);
    send_byte(CH_CR);
  endtask

  task automatic test_malformed_commands();
    send_text("@$T=-1,2");
    send_byte(CH_LF);
    send_text("@$T=1,+2");
    send_byte(CH_LF);
    send_text("@$T=,5");
    send_byte(CH_LF);
    send_text("@$T=5,");
    send_byte(CH_LF);
    send_text("@$T=5");
    send_byte(CH_CR);
    send_text("@$T=5 ,6");
    send_byte(CH_CR);
    send_text("@$");
    send_byte(CH_LOW_T);
    send_text("=1,2");
    send_byte(CH_LF);
    send_text("@$T1,2");
    send_byte(CH_LF);
  endtask

  task automatic test_overlong_lines();
    // fill up to the limit and drop a few bytes past it
    send_text("@$T=12,34");
    send_fill(KEEP_LIMIT - 7 + 3);
    send_byte(CH_LF);
    // the cut falls inside the low number
    send_text("@$T=");
    repeat (KEEP_LIMIT - 6) send_byte(CH_SPACE);
    send_text("12,3456");
    send_byte(CH_CR);
  endtask

  task automatic test_backpressure();
    sender_gaps = 1'b0;
    stall_req   = LONG_STALL;
    repeat (20) begin
      send_text("@$T=7,9");
      send_byte(CH_CR);
    end
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_lines();
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (bytes_sent - start >= RANDOM_BYTES - CALM_BYTES) calm = 1'b1;
      sender_gaps = $urandom_range(0, 3) != 0;
      random_line();
    end
    calm = 1'b1;
  endtask

  initial begin
    int unsigned waited;
    rst_ni        <= 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_time_commands();
    test_framing();
    test_malformed_commands();
    test_overlong_lines();
    test_backpressure();
    test_random_lines();

    rx_if.valid <= 1'b0;
    waited = 0;
    while (pending_lines.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (pending_lines.size() != 0) begin
      errors++;
      $display("%0t: %0d line results never arrived", $time, pending_lines.size());
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== framed_line_time_command_parser_top.f =====
+incdir+design
design/fltcp_pkg.sv
design/fltcp_ifs.sv
design/fltcp_front.sv
design/fltcp_queue.sv
design/fltcp_back.sv
design/framed_line_time_command_parser_top.sv
test/tb.sv
